@@ rtl/core/lefz_pkg.sv @@
// package for the line editor and field tokenizer
// holds sizes, character codes, state encoding and character class functions
`default_nettype none

package lefz_pkg;

  // line and field limits
  localparam int LINE_MAX  = 80;
  localparam int FIELD_MAX = 5;

  // derived widths
  localparam int PTR_W  = $clog2(LINE_MAX + 1);
  localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int FLD_W  = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;
  localparam int CNT_W  = $clog2(FIELD_MAX + 1);

  // fixed port widths
  localparam int CHAR_W    = 8;
  localparam int OUT_POS_W = 7;
  localparam int OUT_IDX_W = 3;
  localparam int OUT_CNT_W = 3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'd122;
  localparam logic [CHAR_W-1:0] CH_D0    = 8'd48;
  localparam logic [CHAR_W-1:0] CH_D9    = 8'd57;

  // field type codes
  localparam logic TYPE_ALPHA   = 1'b0;
  localparam logic TYPE_NUMERIC = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } lefz_state_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] ch);
    return ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) || ((ch >= CH_LC_A) && (ch <= CH_LC_Z));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
    return (ch >= CH_D0) && (ch <= CH_D9);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lefz_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lefz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                  wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/line_editor_field_tokenizer_unit.sv @@
// line editor and field tokenizer, top level
// depends on lefz_pkg and lefz_ram
//
// usage
//   in_* channel: one received character per request (valid/ready)
//   backspace and delete remove the last stored character, cr or lf end the
//   line, the LINE_MAX-th stored character also ends it, other control
//   characters are dropped and bytes of 128 and up are stored as delimiters
//   out_* channel: one request per recorded field at line end, out_last on
//   the final one; a line without fields gives a single request with a zero
//   field count
// line end processing
//   a character that does not end the line leaves in_ready high
//   a line end starts a scan of the stored characters, one read at a time,
//   through the single read port of the line store and the one character
//   classifier, then one result request per cycle while out_ready is high
//   in_ready is low from the line end until the last result is taken
// reset and stalls
//   synchronous active-low reset empties the line and returns to collecting
//   a stalled receiver holds the current result request and the sequencer
`default_nettype none

module line_editor_field_tokenizer_unit
  import lefz_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [CHAR_W-1:0]      in_rx_char,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_field_type,
  output logic [OUT_POS_W-1:0]   out_field_start,
  output logic [OUT_IDX_W-1:0]   out_field_index,
  output logic [OUT_CNT_W-1:0]   out_field_count,
  output logic [OUT_POS_W-1:0]   out_line_length,
  output logic                   out_fields_dropped,
  output logic                   out_last
);

  // control state
  lefz_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;         // write pointer into the line store
  logic [PTR_W-1:0]  len_r, len_nxt;       // length of the finished line
  logic [PTR_W-1:0]  scan_r, scan_nxt;     // next address issued to the store
  logic              tst_vld_r, tst_vld_nxt; // read data in flight is valid
  logic [ADDR_W-1:0] tst_pos_r, tst_pos_nxt; // position of that read data
  logic              after_r, after_nxt;   // previous char was a delimiter
  logic [CNT_W-1:0]  found_r, found_nxt;
  logic              dropped_r, dropped_nxt;
  logic [FLD_W-1:0]  emit_r, emit_nxt;

  // field table, payload only
  logic [ADDR_W-1:0] starts_r [FIELD_MAX];
  logic              types_r  [FIELD_MAX];
  logic              fld_we;
  logic              fld_type;

  // line store port
  logic              st_we;
  logic [ADDR_W-1:0] st_raddr;
  logic [CHAR_W-1:0] st_rdata;

  // input decode
  logic              in_fire, out_fire;
  logic              is_erase, is_eol, is_print;
  logic [PTR_W-1:0]  wp_inc;
  logic              line_full;
  logic              issue;
  logic              ch_alpha, ch_digit;
  logic              rec_last;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign is_erase  = (in_rx_char == CH_BS) || (in_rx_char == CH_DEL);
  assign is_eol    = (in_rx_char == CH_LF) || (in_rx_char == CH_CR);
  assign is_print  = !is_erase && (in_rx_char >= CH_SPACE);
  assign wp_inc    = wp_r + PTR_W'(1);
  assign line_full = (wp_inc == PTR_W'(LINE_MAX));

  // scan pipeline: the store read is registered, so data is classified in the cycle after its address goes out
  assign issue    = (state_r == ST_SCAN) && (scan_r < len_r);
  assign st_raddr = scan_r[ADDR_W-1:0];
  assign st_we    = in_fire && is_print;

  // the shared classifier
  assign ch_alpha = is_alpha(st_rdata);
  assign ch_digit = is_digit(st_rdata);
  assign fld_type = ch_digit ? TYPE_NUMERIC : TYPE_ALPHA;

  lefz_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (wp_r[ADDR_W-1:0]),
    .wdata (in_rx_char),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign rec_last = (CNT_W'(emit_r) + CNT_W'(1)) == found_r;

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    len_nxt     = len_r;
    scan_nxt    = scan_r;
    tst_vld_nxt = 1'b0;
    tst_pos_nxt = tst_pos_r;
    after_nxt   = after_r;
    found_nxt   = found_r;
    dropped_nxt = dropped_r;
    emit_nxt    = emit_r;
    fld_we      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (is_erase) begin
            if (wp_r != '0) begin
              wp_nxt = wp_r - PTR_W'(1);
            end
          end else if (is_eol || (is_print && line_full)) begin
            // line end: snapshot the length and start the scan
            len_nxt     = is_eol ? wp_r : wp_inc;
            wp_nxt      = '0;
            scan_nxt    = '0;
            after_nxt   = 1'b1;
            found_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_SCAN;
          end else if (is_print) begin
            wp_nxt = wp_inc;
          end else begin
            // dropped control character
            wp_nxt = wp_r;
          end
        end
      end

      ST_SCAN: begin
        if (issue) begin
          scan_nxt    = scan_r + PTR_W'(1);
          tst_pos_nxt = scan_r[ADDR_W-1:0];
        end
        tst_vld_nxt = issue;
        if (tst_vld_r) begin
          if (ch_alpha || ch_digit) begin
            if (after_r) begin
              if (found_r < CNT_W'(FIELD_MAX)) begin
                fld_we    = 1'b1;
                found_nxt = found_r + CNT_W'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
              after_nxt = 1'b0;
            end
          end else begin
            after_nxt = 1'b1;
          end
        end
        if (!issue && !tst_vld_r) begin
          emit_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_fire) begin
          if ((found_r == '0) || rec_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + FLD_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      len_r     <= '0;
      scan_r    <= '0;
      tst_vld_r <= 1'b0;
      after_r   <= 1'b1;
      found_r   <= '0;
      dropped_r <= 1'b0;
      emit_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      len_r     <= len_nxt;
      scan_r    <= scan_nxt;
      tst_vld_r <= tst_vld_nxt;
      after_r   <= after_nxt;
      found_r   <= found_nxt;
      dropped_r <= dropped_nxt;
      emit_r    <= emit_nxt;
    end
  end

  // position of the data in flight needs no reset
  always_ff @(posedge clk) begin
    tst_pos_r <= tst_pos_nxt;
  end

  // field table write, one entry per newly found field
  always_ff @(posedge clk) begin
    if (fld_we) begin
      starts_r[found_r[FLD_W-1:0]] <= tst_pos_r;
      types_r[found_r[FLD_W-1:0]]  <= fld_type;
    end
  end

  // outputs
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    if (found_r == '0) begin
      // field-less line gives a single empty record
      out_field_type     = TYPE_ALPHA;
      out_field_start    = '0;
      out_field_index    = '0;
      out_field_count    = '0;
      out_fields_dropped = 1'b0;
      out_last           = 1'b1;
    end else begin
      out_field_type     = types_r[emit_r];
      out_field_start    = OUT_POS_W'(starts_r[emit_r]);
      out_field_index    = OUT_IDX_W'(emit_r);
      out_field_count    = OUT_CNT_W'(found_r);
      out_fields_dropped = dropped_r;
      out_last           = rec_last;
    end
    out_line_length = OUT_POS_W'(len_r);
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while results pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not ready after last record");

  a_eol_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ((in_rx_char == CH_CR) || (in_rx_char == CH_LF)))
    |=> (state_r == ST_SCAN))
    else $error("line end did not start scan");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= CNT_W'(FIELD_MAX))
    else $error("field count overflow");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (wp_r < PTR_W'(LINE_MAX)))
    else $error("write pointer past line limit while collecting");

endmodule

`default_nettype wire
